@@ src/lspa_pkg.sv @@
`default_nettype none

package lspa_pkg;

  localparam int SLOTS_DEF = 16;

  localparam int OPCODE_W = 2;
  localparam int SOCKET_W = 16;
  localparam int HANDLE_W = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CLEAR   = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_NULL    = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_DOUBLE  = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

endpackage

`default_nettype wire

@@ src/lifo_slot_pool_allocator_core.sv @@
`default_nettype none

// Slot pool allocator with a LIFO free list of SLOTS slots held in flip-flops.
// Every operation (acquire, release, clear all) is decided in the cycle it is
// accepted and its single result comes out of an output register in the next
// cycle, so one item is taken per clock when the result side keeps up; a clear
// rebuilds the whole list in that same cycle. The input side stays
// ready while the output register is empty or being drained. active_count
// shows the low five bits of the count of busy slots after the operation.

module lifo_slot_pool_allocator_core #(
  parameter int SLOTS = lspa_pkg::SLOTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [lspa_pkg::OPCODE_W-1:0] in_opcode,
  input  wire logic [lspa_pkg::SOCKET_W-1:0] in_client_socket,
  input  wire logic [lspa_pkg::HANDLE_W-1:0] in_handle_in,

  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [lspa_pkg::STATUS_W-1:0]      out_status,
  output logic [lspa_pkg::HANDLE_W-1:0]      out_handle_out,
  output logic                               out_reused,
  output logic [lspa_pkg::SOCKET_W-1:0]      out_socket_out,
  output logic [lspa_pkg::COUNT_W-1:0]       out_active_count
);

  localparam int IW = $clog2(SLOTS);
  localparam int HW = $clog2(SLOTS + 1);

  // free list and slot flags
  logic [HW-1:0]    head_r, head_nxt;
  logic [HW-1:0]    link_r    [SLOTS];
  logic [HW-1:0]    link_nxt  [SLOTS];
  logic [SLOTS-1:0] busy_r, busy_nxt;
  logic [SLOTS-1:0] created_r, created_nxt;
  logic [HW-1:0]    cnt_r, cnt_nxt;

  // result register
  logic                          out_valid_r, out_valid_nxt;
  lspa_pkg::status_t             status_r, status_nxt;
  logic [lspa_pkg::HANDLE_W-1:0] hout_r, hout_nxt;
  logic                          reused_r, reused_nxt;
  logic [lspa_pkg::SOCKET_W-1:0] sout_r, sout_nxt;
  logic [lspa_pkg::COUNT_W-1:0]  count_r, count_nxt;

  logic                          accept;
  logic [IW-1:0]                 acq_idx;
  logic [lspa_pkg::HANDLE_W-1:0] h_m1;
  logic [IW-1:0]                 rel_idx;
  logic [HW+lspa_pkg::COUNT_W-1:0] cnt_ext;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign acq_idx = head_r[IW-1:0];
  assign h_m1    = in_handle_in - lspa_pkg::HANDLE_W'(1);
  assign rel_idx = h_m1[IW-1:0];
  assign cnt_ext = {{lspa_pkg::COUNT_W{1'b0}}, cnt_nxt};

  always_comb begin
    head_nxt    = head_r;
    link_nxt    = link_r;
    busy_nxt    = busy_r;
    created_nxt = created_r;
    cnt_nxt     = cnt_r;
    status_nxt  = lspa_pkg::ST_NULL;
    hout_nxt    = '0;
    reused_nxt  = 1'b0;
    sout_nxt    = '0;
    unique case (lspa_pkg::opcode_t'(in_opcode))
      lspa_pkg::OP_ACQUIRE: begin
        // a head at or past the end mark counts as an empty list
        if (head_r >= HW'(SLOTS)) begin
          status_nxt = lspa_pkg::ST_FULL;
        end else begin
          head_nxt             = link_r[acq_idx];
          link_nxt[acq_idx]    = HW'(SLOTS);
          reused_nxt           = created_r[acq_idx];
          created_nxt[acq_idx] = 1'b1;
          busy_nxt[acq_idx]    = 1'b1;
          cnt_nxt              = cnt_r + HW'(1);
          status_nxt           = lspa_pkg::ST_OK;
          hout_nxt             = lspa_pkg::HANDLE_W'(acq_idx) + lspa_pkg::HANDLE_W'(1);
          sout_nxt             = in_client_socket;
        end
      end
      lspa_pkg::OP_RELEASE: begin
        if (in_handle_in == '0) begin
          status_nxt = lspa_pkg::ST_NULL;
        end else if (in_handle_in > lspa_pkg::HANDLE_W'(SLOTS) || !created_r[rel_idx]) begin
          status_nxt = lspa_pkg::ST_UNKNOWN;
        end else if (!busy_r[rel_idx]) begin
          status_nxt = lspa_pkg::ST_DOUBLE;
        end else begin
          busy_nxt[rel_idx] = 1'b0;
          link_nxt[rel_idx] = head_r;
          head_nxt          = HW'(rel_idx);
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - HW'(1);
          end
          status_nxt = lspa_pkg::ST_OK;
        end
      end
      lspa_pkg::OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          link_nxt[i] = HW'(i + 1);
        end
        busy_nxt    = '0;
        created_nxt = '0;
        head_nxt    = '0;
        cnt_nxt     = '0;
        status_nxt  = lspa_pkg::ST_CLEARED;
      end
      default: begin
        status_nxt = lspa_pkg::ST_NULL;
      end
    endcase
    count_nxt = cnt_ext[lspa_pkg::COUNT_W-1:0];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        link_r[i] <= HW'(i + 1);
      end
      head_r      <= '0;
      busy_r      <= '0;
      created_r   <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        link_r    <= link_nxt;
        head_r    <= head_nxt;
        busy_r    <= busy_nxt;
        created_r <= created_nxt;
        cnt_r     <= cnt_nxt;
      end
    end
  end

  // payload of the result register, loaded on each input transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      hout_r   <= hout_nxt;
      reused_r <= reused_nxt;
      sout_r   <= sout_nxt;
      count_r  <= count_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_handle_out   = hout_r;
  assign out_reused       = reused_r;
  assign out_socket_out   = sout_r;
  assign out_active_count = count_r;

endmodule

`default_nettype wire

@@ src/lspa_checker.sv @@
`default_nettype none

module lspa_checker #(
  parameter int SLOTS = lspa_pkg::SLOTS_DEF
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [lspa_pkg::STATUS_W-1:0] out_status,
  input wire logic [lspa_pkg::HANDLE_W-1:0] out_handle_out,
  input wire logic                          out_reused,
  input wire logic [lspa_pkg::SOCKET_W-1:0] out_socket_out
);

  // a waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_handle_out))
    else $error("result changed while stalled");

  // the block stays open while the output register is empty
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // only a successful acquire carries a slot
  a_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != lspa_pkg::ST_OK |->
      out_handle_out == '0 && !out_reused && out_socket_out == '0)
    else $error("slot fields set on a result without an acquired slot");

  a_handle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_handle_out <= lspa_pkg::HANDLE_W'(SLOTS))
    else $error("handle beyond pool");

  // an acquire result that directly follows a clear never reports a reused slot
  a_clear_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_status == lspa_pkg::ST_CLEARED ##1
      out_valid && out_status == lspa_pkg::ST_OK && out_handle_out != '0 |->
      !out_reused)
    else $error("slot reused right after clear");

endmodule

bind lifo_slot_pool_allocator_core lspa_checker #(.SLOTS(SLOTS)) u_lspa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_handle_out (out_handle_out),
  .out_reused     (out_reused),
  .out_socket_out (out_socket_out)
);

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int SLOTS = lspa_pkg::SLOTS_DEF;
  localparam logic [lspa_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_OPS = 1100;
  localparam int IDLE_PCT = 37;

  typedef struct {
    logic [lspa_pkg::OPCODE_W-1:0] opcode;
    logic [lspa_pkg::SOCKET_W-1:0] socket;
    logic [lspa_pkg::HANDLE_W-1:0] handle;
  } pool_op_t;

  typedef struct {
    lspa_pkg::status_t             status;
    logic [lspa_pkg::HANDLE_W-1:0] handle_out;
    logic                          reused;
    logic [lspa_pkg::SOCKET_W-1:0] socket_out;
    logic [lspa_pkg::COUNT_W-1:0]  count;
  } pool_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [lspa_pkg::OPCODE_W-1:0] in_opcode = '0;
  logic [lspa_pkg::SOCKET_W-1:0] in_client_socket = '0;
  logic [lspa_pkg::HANDLE_W-1:0] in_handle_in = '0;

  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [lspa_pkg::STATUS_W-1:0] out_status;
  logic [lspa_pkg::HANDLE_W-1:0] out_handle_out;
  logic                          out_reused;
  logic [lspa_pkg::SOCKET_W-1:0] out_socket_out;
  logic [lspa_pkg::COUNT_W-1:0]  out_active_count;

  pool_op_t     pending_ops[$];
  pool_result_t expected_results[$];
  int           accepted_ops = 0;
  int           mismatches = 0;
  logic         steady;

  // shadow of the free list
  int pool_head;
  int pool_next[SLOTS];
  bit pool_busy[SLOTS];
  bit pool_made[SLOTS];
  int busy_count;

  lifo_slot_pool_allocator_core #(.SLOTS(SLOTS)) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_client_socket (in_client_socket),
    .in_handle_in     (in_handle_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_handle_out   (out_handle_out),
    .out_reused       (out_reused),
    .out_socket_out   (out_socket_out),
    .out_active_count (out_active_count)
  );

  always #5 clk = ~clk;

  // no idling on either side for a stretch in the middle of the run
  assign steady = (accepted_ops >= 500) && (accepted_ops < 700);

  task automatic rebuild_pool();
    for (int i = 0; i < SLOTS; i++) begin
      pool_next[i] = i + 1;
      pool_busy[i] = 1'b0;
      pool_made[i] = 1'b0;
    end
    pool_head = 0;
    busy_count = 0;
  endtask

  task automatic predict_outcome(input pool_op_t op, output pool_result_t res);
    int s;
    res.status = lspa_pkg::ST_NULL;
    res.handle_out = '0;
    res.reused = 1'b0;
    res.socket_out = '0;
    case (op.opcode)
      lspa_pkg::OP_ACQUIRE: begin
        // a head outside the pool counts as an empty list
        if (pool_head >= SLOTS || pool_head < 0) begin
          res.status = lspa_pkg::ST_FULL;
        end else begin
          s = pool_head;
          pool_head = pool_next[s];
          pool_next[s] = SLOTS;
          res.reused = pool_made[s];
          pool_made[s] = 1'b1;
          pool_busy[s] = 1'b1;
          busy_count++;
          res.status = lspa_pkg::ST_OK;
          res.handle_out = lspa_pkg::HANDLE_W'(s + 1);
          res.socket_out = op.socket;
        end
      end
      lspa_pkg::OP_RELEASE: begin
        if (op.handle == 0) begin
          res.status = lspa_pkg::ST_NULL;
        end else if (op.handle > SLOTS || !pool_made[op.handle - 1]) begin
          res.status = lspa_pkg::ST_UNKNOWN;
        end else if (!pool_busy[op.handle - 1]) begin
          res.status = lspa_pkg::ST_DOUBLE;
        end else begin
          s = op.handle - 1;
          pool_busy[s] = 1'b0;
          pool_next[s] = pool_head;
          pool_head = s;
          if (busy_count > 0) busy_count--;
          res.status = lspa_pkg::ST_OK;
        end
      end
      lspa_pkg::OP_CLEAR: begin
        rebuild_pool();
        res.status = lspa_pkg::ST_CLEARED;
      end
      default: ;
    endcase
    res.count = lspa_pkg::COUNT_W'(busy_count);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic pool_op_t make_op(logic [lspa_pkg::OPCODE_W-1:0] opc, int sock, int hnd);
    pool_op_t op;
    op.opcode = opc;
    op.socket = lspa_pkg::SOCKET_W'(sock);
    op.handle = lspa_pkg::HANDLE_W'(hnd);
    return op;
  endfunction

  // driver
  always @(posedge clk) begin
    pool_result_t res;
    pool_op_t     nxt;
    bit           idle;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        nxt.opcode = in_opcode;
        nxt.socket = in_client_socket;
        nxt.handle = in_handle_in;
        predict_outcome(nxt, res);
        expected_results.push_back(res);
        accepted_ops <= accepted_ops + 1;
      end
      if (!in_valid || in_ready) begin
        idle = !steady && ($urandom_range(99) < IDLE_PCT);
        if (pending_ops.size() > 0 && !idle) begin
          nxt = pending_ops.pop_front();
          in_valid <= 1'b1;
          in_opcode <= nxt.opcode;
          in_client_socket <= nxt.socket;
          in_handle_in <= nxt.handle;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pool_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("transfer with nothing pending, status", out_status, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_handle_out !== want.handle_out)
            report_mismatch("handle_out", out_handle_out, want.handle_out);
          if (out_reused !== want.reused)
            report_mismatch("reused", out_reused, want.reused);
          if (out_socket_out !== want.socket_out)
            report_mismatch("socket_out", out_socket_out, want.socket_out);
          if (out_active_count !== want.count)
            report_mismatch("active_count", out_active_count, want.count);
        end
      end
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    int acq_pct;
    int r;
    rebuild_pool();

    // directed: extremes, every status, reuse, full pool, clear
    pending_ops.push_back(make_op(lspa_pkg::OP_ACQUIRE, 16'h0000, 0));
    pending_ops.push_back(make_op(lspa_pkg::OP_ACQUIRE, 16'hFFFF, 255));
    pending_ops.push_back(make_op(lspa_pkg::OP_RELEASE, 16'hFFFF, 0));
    pending_ops.push_back(make_op(lspa_pkg::OP_RELEASE, 0, 255));
    pending_ops.push_back(make_op(lspa_pkg::OP_RELEASE, 0, SLOTS + 1));
    pending_ops.push_back(make_op(lspa_pkg::OP_RELEASE, 0, SLOTS));
    pending_ops.push_back(make_op(lspa_pkg::OP_RELEASE, 0, 1));
    pending_ops.push_back(make_op(lspa_pkg::OP_RELEASE, 0, 1));
    pending_ops.push_back(make_op(lspa_pkg::OP_ACQUIRE, 16'hA5A5, 0));
    pending_ops.push_back(make_op(OP_UNUSED, 16'hFFFF, 255));
    for (int i = 0; i < SLOTS - 2; i++)
      pending_ops.push_back(make_op(lspa_pkg::OP_ACQUIRE, $urandom_range(65535),
        $urandom_range(255)));
    pending_ops.push_back(make_op(lspa_pkg::OP_ACQUIRE, 16'h5A5A, 0));
    pending_ops.push_back(make_op(lspa_pkg::OP_CLEAR, 16'hFFFF, 255));
    pending_ops.push_back(make_op(lspa_pkg::OP_RELEASE, 0, 1));

    // random: acquire bias changes every hundred items so the pool swings
    // between nearly empty and full
    acq_pct = 50;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 100 == 0) begin
        r = $urandom_range(2);
        acq_pct = (r == 0) ? 30 : (r == 1) ? 50 : 65;
      end
      r = $urandom_range(99);
      if (r < acq_pct) begin
        pending_ops.push_back(make_op(lspa_pkg::OP_ACQUIRE, $urandom_range(65535),
          $urandom_range(255)));
      end else if (r < 96) begin
        r = $urandom_range(99);
        pending_ops.push_back(make_op(lspa_pkg::OP_RELEASE, $urandom_range(65535),
          (r < 80) ? $urandom_range(SLOTS, 1) : (r < 90) ? 0 : $urandom_range(255)));
      end else if (r < 98) begin
        pending_ops.push_back(make_op(lspa_pkg::OP_CLEAR, $urandom_range(65535),
          $urandom_range(255)));
      end else begin
        pending_ops.push_back(make_op(OP_UNUSED, $urandom_range(65535), $urandom_range(255)));
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (5) @(posedge clk);

    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

@@ sim.f @@
src/lspa_pkg.sv
src/lifo_slot_pool_allocator_core.sv
src/lspa_checker.sv
tb/sv/testbench.sv
